// File: rtl/core/mfmd_pkg.sv
// Shared types and constants for the motor feedback multi-turn decoder.
`default_nettype none

package mfmd_pkg;

   // Per-motor tracking state as held in the slot memory
   typedef struct packed {
      logic [7:0]         seen;
      logic [15:0]        offset;
      logic signed [31:0] turns;
      logic [15:0]        prev;
   } slot_type;

   // Per-request tracking result handed from the update stage to the scaling pipe
   typedef struct packed {
      logic [3:0]         motor_id;
      logic               calibrating;
      logic [15:0]        enc;
      logic signed [16:0] delta;
      logic signed [31:0] turns;
      logic signed [16:0] off_diff;
      logic signed [15:0] speed;
      logic signed [15:0] current;
      logic [7:0]         temp;
   } track_type;

   localparam logic [7:0]         CAL_COUNT_RESET = 8'd50;
   localparam logic [7:0]         SEEN_LIMIT      = 8'hFF;
   localparam logic signed [31:0] TURNS_MAX       = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] TURNS_MIN       = -32'sh7FFF_FFFF - 32'sd1;

   // 360 * 256 = 45 << 11
   localparam int unsigned ANGLE_MUL   = 45;
   localparam int unsigned ANGLE_SHIFT = 11;

   localparam int unsigned RSP_DATA_W = 208;
   localparam int unsigned RSP_USER_W = 5;

endpackage

`default_nettype wire

// File: rtl/core/motor_feedback_multiturn_decoder_top.sv
// Top level: request intake, per-motor read-modify-write stage and result pipe.
// An accepted request passes through the slot read and update, the total, the
// multiply and the scale into the output register.
// Throughput: one request per cycle unless the response side stalls; the slot memory
// is read on accept and written back as the request leaves the update stage, with the
// last write forwarded to the next read. ENCODER_SPAN must be a power of two. Synchronous
// reset clears all motor state at once (valid bits) and sets calibration_count to 50.
`default_nettype none

module motor_feedback_multiturn_decoder_top #(
   parameter int unsigned MOTOR_SLOTS  = 16,
   parameter int unsigned ENCODER_SPAN = 8192
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // csr
   input  wire logic                                csr_wr_en,
   input  wire logic [7:0]                          csr_wr_data,   // calibration_count
   // request
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [55:0]                         req_tdata,     // frame_data
   input  wire logic [3:0]                          req_tuser,     // motor_index
   // response
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // encoder_position[15:0], step_delta[32:16], turn_count[64:33], total_count[112:65],
   // shaft_angle[164:113], shaft_speed[180:165], motor_current[196:181],
   // motor_temperature[204:197], zero pad
   output logic [mfmd_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // motor_id[3:0], calibrating[4]
   output logic [mfmd_pkg::RSP_USER_W-1:0]          rsp_tuser
);
   import mfmd_pkg::*;

   localparam int unsigned AW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
   localparam logic signed [17:0] SPAN_S = 18'(ENCODER_SPAN);
   localparam logic signed [17:0] HALF_S = 18'(ENCODER_SPAN / 2);

   logic [7:0]   cal_count_ff, cal_count_in;
   logic         s1_valid_ff, s1_valid_in;
   logic [3:0]   s1_idx_ff;
   logic [55:0]  s1_frame_ff;

   logic         accept, scale_ready;
   slot_type     rec, rec_new;
   track_type    trk;
   logic         in_range, calib, wrap_dn, wrap_up;
   logic [7:0]   seen_new;
   logic [15:0]  enc;
   logic signed [17:0] d, delta18;
   logic signed [31:0] turns_new;
   logic         wr_en;

   assign req_tready = !s1_valid_ff || scale_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cal_count_in = csr_wr_en ? csr_wr_data : cal_count_ff;
      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_count_ff <= CAL_COUNT_RESET;
         s1_valid_ff  <= 1'b0;
      end else begin
         cal_count_ff <= cal_count_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= req_tuser;
         s1_frame_ff <= req_tdata;
      end
   end

   mfmd_slot_store #(
      .MOTOR_SLOTS (MOTOR_SLOTS),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (AW'(req_tuser)),
      .rd_data (rec),
      .wr_en   (wr_en),
      .wr_addr (AW'(s1_idx_ff)),
      .wr_data (rec_new)
   );

   // update stage
   always_comb begin
      enc      = s1_frame_ff[55:40];
      in_range = 7'(s1_idx_ff) < 7'(MOTOR_SLOTS);
      seen_new = (rec.seen == SEEN_LIMIT) ? SEEN_LIMIT : rec.seen + 8'd1;
      calib    = !in_range || (seen_new < cal_count_ff);

      d       = $signed({2'b00, enc}) - $signed({2'b00, rec.prev});
      wrap_dn = d > HALF_S;
      wrap_up = d < -HALF_S;
      turns_new = rec.turns;
      delta18   = d;
      if (wrap_dn) begin
         delta18 = d - SPAN_S;
         if (rec.turns != TURNS_MIN) begin
            turns_new = rec.turns - 32'sd1;
         end
      end else if (wrap_up) begin
         delta18 = d + SPAN_S;
         if (rec.turns != TURNS_MAX) begin
            turns_new = rec.turns + 32'sd1;
         end
      end

      rec_new.seen = seen_new;
      rec_new.prev = enc;
      if (calib) begin
         rec_new.offset = enc;
         rec_new.turns  = rec.turns;
      end else begin
         rec_new.offset = rec.offset;
         rec_new.turns  = turns_new;
      end

      trk.motor_id    = s1_idx_ff;
      trk.calibrating = calib;
      trk.enc         = enc;
      trk.speed       = $signed(s1_frame_ff[39:24]);
      trk.current     = $signed(s1_frame_ff[23:8]);
      trk.temp        = s1_frame_ff[7:0];
      if (calib) begin
         trk.delta    = '0;
         trk.turns    = '0;
         trk.off_diff = '0;
      end else begin
         trk.delta    = delta18[16:0];
         trk.turns    = turns_new;
         trk.off_diff = $signed({1'b0, enc}) - $signed({1'b0, rec.offset});
      end
   end

   assign wr_en = s1_valid_ff && scale_ready && in_range;

   mfmd_scale #(
      .ENCODER_SPAN (ENCODER_SPAN)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .trk_valid  (s1_valid_ff),
      .trk_ready  (scale_ready),
      .trk_data   (trk),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/core/mfmd_slot_store.sv
// Per-motor state memory with registered read, valid bits and write forwarding.
`default_nettype none

module mfmd_slot_store #(
   parameter int unsigned MOTOR_SLOTS = 16,
   parameter int unsigned AW          = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output mfmd_pkg::slot_type     rd_data,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  mfmd_pkg::slot_type     wr_data
);
   import mfmd_pkg::*;

   slot_type                slot_mem_ff [MOTOR_SLOTS];
   logic [MOTOR_SLOTS-1:0]  valid_ff;
   logic [MOTOR_SLOTS-1:0]  valid_in;
   slot_type                rd_data_ff;
   logic                    rd_valid_ff;
   logic [AW-1:0]           rd_addr_ff;
   // last write, covers a read issued on the same edge as the write
   slot_type                fwd_data_ff;
   logic [AW-1:0]           fwd_addr_ff;
   logic                    fwd_valid_ff;
   logic                    fwd_valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      fwd_valid_in = fwd_valid_ff | wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
         fwd_data_ff          <= wr_data;
         fwd_addr_ff          <= wr_addr;
      end
      if (rd_en) begin
         rd_data_ff  <= slot_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) begin
         rd_data = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_data = rd_data_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/mfmd_scale.sv
// Total count and angle pipeline: total, constant multiply, scale and clamp, output register.
`default_nettype none

module mfmd_scale #(
   parameter int unsigned ENCODER_SPAN = 8192
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   trk_valid,
   output logic                                        trk_ready,
   input  mfmd_pkg::track_type                         trk_data,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [mfmd_pkg::RSP_DATA_W-1:0]             rsp_tdata,
   output logic [mfmd_pkg::RSP_USER_W-1:0]             rsp_tuser
);
   import mfmd_pkg::*;

   localparam int unsigned LOG_SPAN = $clog2(ENCODER_SPAN);
   localparam int unsigned SH_UP    = (LOG_SPAN <= ANGLE_SHIFT) ? ANGLE_SHIFT - LOG_SPAN : 0;
   localparam int unsigned SH_DN    = (LOG_SPAN > ANGLE_SHIFT) ? LOG_SPAN - ANGLE_SHIFT : 0;

   localparam logic signed [49:0] TOT_HI = 50'sd140737488355327;
   localparam logic signed [49:0] TOT_LO = -50'sd140737488355328;
   localparam logic signed [59:0] ANG_HI = 60'sd2251799813685247;
   localparam logic signed [59:0] ANG_LO = -60'sd2251799813685248;
   localparam logic signed [59:0] BIAS   = 60'((64'd1 << SH_DN) - 64'd1);
   localparam logic signed [54:0] MUL_K  = 55'(ANGLE_MUL);

   // stage 2: total count
   logic                s2_valid_ff, s2_valid_in;
   track_type           s2_trk_ff;
   logic signed [47:0]  s2_total_ff, s2_total_in;
   // stage 3: total times 45
   logic                s3_valid_ff, s3_valid_in;
   track_type           s3_trk_ff;
   logic signed [47:0]  s3_total_ff;
   logic signed [54:0]  s3_prod_ff, s3_prod_in;
   // output register
   logic                out_valid_ff, out_valid_in;
   track_type           out_trk_ff;
   logic signed [47:0]  out_total_ff;
   logic signed [51:0]  out_angle_ff, out_angle_in;

   logic                out_ready, s3_ready, s2_ready;
   logic signed [49:0]  turns_ext, diff_ext, total_full;
   logic signed [59:0]  prod_ext, prod_bias, angle_full;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign trk_ready = s2_ready;

   always_comb begin
      turns_ext  = {{18{trk_data.turns[31]}}, trk_data.turns};
      diff_ext   = {{33{trk_data.off_diff[16]}}, trk_data.off_diff};
      total_full = (turns_ext <<< LOG_SPAN) + diff_ext;
      if (total_full > TOT_HI) begin
         s2_total_in = TOT_HI[47:0];
      end else if (total_full < TOT_LO) begin
         s2_total_in = TOT_LO[47:0];
      end else begin
         s2_total_in = total_full[47:0];
      end

      s3_prod_in = $signed({{7{s2_total_ff[47]}}, s2_total_ff}) * MUL_K;

      // divide by the span with truncation toward zero
      prod_ext   = {{5{s3_prod_ff[54]}}, s3_prod_ff};
      prod_bias  = s3_prod_ff[54] ? prod_ext + BIAS : prod_ext;
      angle_full = (prod_bias >>> SH_DN) <<< SH_UP;
      if (angle_full > ANG_HI) begin
         out_angle_in = ANG_HI[51:0];
      end else if (angle_full < ANG_LO) begin
         out_angle_in = ANG_LO[51:0];
      end else begin
         out_angle_in = angle_full[51:0];
      end

      s2_valid_in  = s2_ready ? trk_valid : s2_valid_ff;
      s3_valid_in  = s3_ready ? s2_valid_ff : s3_valid_ff;
      out_valid_in = out_ready ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_trk_ff   <= trk_data;
         s2_total_ff <= s2_total_in;
      end
      if (s3_ready) begin
         s3_trk_ff   <= s2_trk_ff;
         s3_total_ff <= s2_total_ff;
         s3_prod_ff  <= s3_prod_in;
      end
      if (out_ready) begin
         out_trk_ff   <= s3_trk_ff;
         out_total_ff <= s3_total_ff;
         out_angle_ff <= out_angle_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_trk_ff.calibrating, out_trk_ff.motor_id};
   assign rsp_tdata  = {3'b000, out_trk_ff.temp, out_trk_ff.current, out_trk_ff.speed,
                        out_angle_ff, out_total_ff, out_trk_ff.turns, out_trk_ff.delta,
                        out_trk_ff.enc};

endmodule

`default_nettype wire

// File: dv/mfmd_checker.sv
// Checker for the multi-turn decoder: predicts each response from the observed requests.
`default_nettype none

module mfmd_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [55:0]  req_tdata,
   input  wire logic [3:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [207:0] rsp_tdata,
   input  wire logic [4:0]   rsp_tuser,
   output int                fail_count,
   output int                outstanding
);
   import mfmd_pkg::*;

   localparam int     SLOTS     = 16;
   localparam longint SPAN      = 8192;
   localparam longint DEG_UNITS = 92160;   // 360 * 256
   localparam longint ANGLE_HI  = 64'sd2251799813685247;

   typedef struct {
      logic [3:0]         motor_id;
      logic               calibrating;
      logic [15:0]        enc;
      logic [16:0]        delta;
      logic [31:0]        turns;
      logic [47:0]        total;
      logic [51:0]        angle;
      logic [15:0]        speed;
      logic [15:0]        current;
      logic [7:0]         temp;
   } decoded_type;

   logic [7:0]         cal_count;
   logic [15:0]        last_pos  [SLOTS];
   logic signed [31:0] turn_acc  [SLOTS];
   logic [15:0]        zero_pos  [SLOTS];
   logic [7:0]         seen_cnt  [SLOTS];
   decoded_type        pending_decodes[$];

   function automatic decoded_type decode_frame(logic [3:0] slot, logic [55:0] frame);
      decoded_type r;
      longint      d, t, tot, q, rem, ang;
      r.motor_id    = slot;
      r.enc         = frame[55:40];
      r.speed       = frame[39:24];
      r.current     = frame[23:8];
      r.temp        = frame[7:0];
      r.calibrating = 1'b1;
      r.delta       = '0;
      r.turns       = '0;
      r.total       = '0;
      r.angle       = '0;
      if (seen_cnt[slot] != SEEN_LIMIT)
         seen_cnt[slot] = seen_cnt[slot] + 8'd1;
      if (seen_cnt[slot] < cal_count) begin
         zero_pos[slot] = r.enc;
         last_pos[slot] = r.enc;
      end else begin
         d = longint'(r.enc) - longint'(last_pos[slot]);
         t = longint'(turn_acc[slot]);
         if (d > SPAN / 2) begin
            if (t > longint'(TURNS_MIN)) t = t - 1;
            d = d - SPAN;
         end else if (d < -(SPAN / 2)) begin
            if (t < longint'(TURNS_MAX)) t = t + 1;
            d = d + SPAN;
         end
         turn_acc[slot] = t[31:0];
         last_pos[slot] = r.enc;
         tot = t * SPAN + longint'(r.enc) - longint'(zero_pos[slot]);
         // truncating split keeps the product in range and rounds toward zero
         q   = tot / SPAN;
         rem = tot % SPAN;
         ang = q * DEG_UNITS + (rem * DEG_UNITS) / SPAN;
         if (ang > ANGLE_HI) ang = ANGLE_HI;
         if (ang < -ANGLE_HI - 1) ang = -ANGLE_HI - 1;
         r.calibrating = 1'b0;
         r.delta       = d[16:0];
         r.turns       = t[31:0];
         r.total       = tot[47:0];
         r.angle       = ang[51:0];
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      decoded_type e;
      if (reset) begin
         cal_count = CAL_COUNT_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            last_pos[i] = '0;
            turn_acc[i] = '0;
            zero_pos[i] = '0;
            seen_cnt[i] = '0;
         end
         pending_decodes.delete();
      end else begin
         if (csr_wr_en)
            cal_count = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_decodes.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               e = pending_decodes.pop_front();
               check_field("motor_id", e.motor_id, rsp_tuser[3:0]);
               check_field("calibrating", e.calibrating, rsp_tuser[4]);
               check_field("encoder_position", e.enc, rsp_tdata[15:0]);
               check_field("step_delta", e.delta, rsp_tdata[32:16]);
               check_field("turn_count", e.turns, rsp_tdata[64:33]);
               check_field("total_count", e.total, rsp_tdata[112:65]);
               check_field("shaft_angle", e.angle, rsp_tdata[164:113]);
               check_field("shaft_speed", e.speed, rsp_tdata[180:165]);
               check_field("motor_current", e.current, rsp_tdata[196:181]);
               check_field("motor_temperature", e.temp, rsp_tdata[204:197]);
            end
         end
         if (req_tvalid && req_tready)
            pending_decodes.push_back(decode_frame(req_tuser, req_tdata));
      end
      outstanding = pending_decodes.size();
   end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench top: clock, reset, request and response traffic, config phases and verdict.
`default_nettype none

module tb_top;
   localparam int STALL_LIMIT = 5000;
   localparam int SPAN        = 8192;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;     // frame_data
   logic [3:0]   req_tuser;     // motor_index
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [207:0] rsp_tdata;     // encoder_position .. motor_temperature, zero pad
   logic [4:0]   rsp_tuser;     // motor_id, calibrating
   int           fail_count;
   int           outstanding;

   int           sender_gap_max;
   bit           hold_req;
   bit           rsp_holding;
   int           idle_cycles;
   int           trk_pos [16];
   int           trk_vel [16];

   motor_feedback_multiturn_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   mfmd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      int rsp_gap_max;
      bit held;
      rsp_tready  = 1'b0;
      rsp_holding = 1'b0;
      held        = 1'b0;
      rsp_gap_max = 16;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req && !held) begin
            held        = 1'b1;
            rsp_holding = 1'b1;
            rsp_tready  = 1'b0;
            repeat (80) @(negedge clock);
            rsp_holding = 1'b0;
         end
         if ($urandom_range(0, 39) == 0)
            rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   function automatic logic [55:0] make_frame(logic [15:0] enc);
      logic [15:0] speed;
      logic [15:0] current;
      logic [7:0]  temp;
      speed   = 16'($urandom);
      current = 16'($urandom);
      temp    = 8'($urandom);
      return {enc, speed, current, temp};
   endfunction

   // entered and left at a falling edge
   task automatic send_frame(logic [3:0] motor, logic [55:0] frame);
      int gap;
      gap = rsp_holding ? 0 : $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = motor;
      req_tdata  = frame;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_and_pause();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_cal_count(logic [7:0] value);
      drain_and_pause();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // mostly smooth encoder trajectories per motor, some arbitrary jumps
   task automatic send_random(int count);
      int          m;
      int          step;
      logic [15:0] enc;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 49) == 0)
            sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         m = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 15);
         if ($urandom_range(0, 9) < 2) begin
            enc = 16'($urandom);
         end else begin
            if ($urandom_range(0, 15) == 0)
               trk_vel[m] = int'($urandom_range(0, 6000)) - 3000;
            step = trk_vel[m] + int'($urandom_range(0, 400)) - 200;
            if ($urandom_range(0, 9) == 0)
               step = int'($urandom_range(4090, 4102)) * (($urandom_range(0, 1) == 0) ? 1 : -1);
            trk_pos[m] = ((trk_pos[m] + step) % SPAN + SPAN) % SPAN;
            enc = trk_pos[m][15:0];
         end
         send_frame(m[3:0], make_frame(enc));
      end
   endtask

   initial begin
      logic [15:0] wrap_walk [12];
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      sender_gap_max = 16;
      hold_req       = 1'b0;
      for (int i = 0; i < 16; i++) begin
         trk_pos[i] = 0;
         trk_vel[i] = 0;
      end
      wrap_walk = '{16'd100, 16'd4196, 16'd100, 16'd4197, 16'd100, 16'd8000,
                    16'd50, 16'd0, 16'hFFFF, 16'd0, 16'd8191, 16'd0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset calibration count: field extremes while calibrating
      send_frame(4'd15, {16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF});
      send_frame(4'd0, 56'd0);
      send_frame(4'd0, {16'h0000, 16'h8000, 16'h7FFF, 8'h00});
      send_random(150);

      // no calibration: wrap thresholds at exactly half span and beyond
      write_cal_count(8'd1);
      foreach (wrap_walk[i])
         send_frame(4'd3, make_frame(wrap_walk[i]));
      send_frame(4'd15, {16'hFFFF, 16'h8000, 16'h7FFF, 8'h00});
      send_random(200);

      // maximum calibration count; receiver holds off so the block backs up
      write_cal_count(8'd255);
      hold_req = 1'b1;
      send_random(200);

      write_cal_count(8'd0);
      send_random(100);

      write_cal_count(8'($urandom_range(2, 254)));
      send_random(150);

      drain_and_pause();
      if (fail_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/mfmd_pkg.sv
rtl/core/mfmd_slot_store.sv
rtl/core/mfmd_scale.sv
rtl/core/motor_feedback_multiturn_decoder_top.sv
dv/mfmd_checker.sv
dv/tb_top.sv
